[rtl/core/bev_pkg.sv]
// Shared types, constants and codes of the button event generator.
package bev_pkg;

	localparam int ROWS        = 5;
	localparam int COLS        = 5;
	localparam int NBTN        = ROWS * COLS;
	localparam int BTN_W       = $clog2(NBTN);
	localparam int BUTTON_W    = 5;
	localparam int REPEAT_SPAN = 1000;

	// event mask bit positions
	localparam int M_PRESS    = 0;
	localparam int M_RELEASE  = 1;
	localparam int M_CLICK    = 2;
	localparam int M_LONG     = 3;
	localparam int M_REPEAT   = 4;
	localparam int M_TOGGLE   = 5;
	localparam int M_TOUCH    = 6;
	localparam int M_USERDRAW = 7;

	localparam logic [15:0] LONG_PRESS_RST = 16'd800;
	localparam logic [15:0] REP_DELAY_RST  = 16'd300;
	localparam logic [7:0]  REP_SLOW_RST   = 8'd100;
	localparam logic [7:0]  REP_SPEED_RST  = 8'd90;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_MODE   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		LED_NONE     = 3'd0,
		LED_PRESSED  = 3'd1,
		LED_DEFAULT  = 3'd2,
		LED_TOUCH    = 3'd3,
		LED_SELECTED = 3'd4,
		LED_ALL_OFF  = 3'd5
	} led_t;

	typedef enum logic [1:0] {
		CFG_LONG_PRESS = 2'd0,
		CFG_REP_DELAY  = 2'd1,
		CFG_REP_SLOW   = 2'd2,
		CFG_REP_SPEED  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [BUTTON_W-1:0] button;
		logic                down;
		logic [31:0]         now_ms;
		logic [7:0]          mode;
	} item_t;

	typedef struct packed {
		logic [15:0] long_press_ms;
		logic [15:0] repeat_delay_ms;
		logic [7:0]  repeat_slow_ms;
		logic [7:0]  repeat_speedup_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  mode;
		logic        pressed;
		logic        touched;
		logic        selected;
		logic        armed;
		logic [31:0] press_stamp;
		logic [31:0] repeat_stamp;
	} entry_t;

	typedef struct packed {
		logic   we;
		logic   clr;
		entry_t ent;
	} wr_t;

	typedef struct packed {
		logic ev_press;
		logic ev_release;
		logic ev_click;
		logic ev_long_click;
		led_t led_action;
		logic pressed;
		logic is_selected;
		logic was_touched;
	} result_t;

endpackage

[rtl/core/bev_in_if.sv]
// Input item channel: command, button index, level, time and mode.
interface bev_in_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [bev_pkg::BUTTON_W-1:0] button;
	logic                         down;
	logic [31:0]                  now_ms;
	logic [7:0]                   mode;

	modport source(output valid, cmd, button, down, now_ms, mode, input ready);
	modport sink(input valid, cmd, button, down, now_ms, mode, output ready);
endinterface

[rtl/core/bev_out_if.sv]
// Result item channel: event flags, LED action and button status.
interface bev_out_if;
	logic       valid;
	logic       ready;
	logic       ev_press;
	logic       ev_release;
	logic       ev_click;
	logic       ev_long_click;
	logic [2:0] led_action;
	logic       pressed;
	logic       is_selected;
	logic       was_touched;

	modport source(output valid, ev_press, ev_release, ev_click, ev_long_click, led_action,
		pressed, is_selected, was_touched, input ready);
	modport sink(input valid, ev_press, ev_release, ev_click, ev_long_click, led_action,
		pressed, is_selected, was_touched, output ready);
endinterface

[rtl/core/bev_cfg_if.sv]
// Configuration write channel: register index and write data.
interface bev_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/bev_table.sv]
// Per-button state table in flops: one read port, one entry write or a clear of all.
module bev_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bev_pkg::BTN_W-1:0] idx,
	input  logic                      en,
	input  bev_pkg::wr_t              wr,
	output bev_pkg::entry_t           rd
);

	logic [bev_pkg::NBTN-1:0][7:0]  mode_q;
	logic [bev_pkg::NBTN-1:0]       pressed_q;
	logic [bev_pkg::NBTN-1:0]       touched_q;
	logic [bev_pkg::NBTN-1:0]       selected_q;
	logic [bev_pkg::NBTN-1:0]       armed_q;
	logic [bev_pkg::NBTN-1:0][31:0] press_stamp_q;
	logic [bev_pkg::NBTN-1:0][31:0] repeat_stamp_q;

	always_comb begin
		rd.mode         = mode_q[idx];
		rd.pressed      = pressed_q[idx];
		rd.touched      = touched_q[idx];
		rd.selected     = selected_q[idx];
		rd.armed        = armed_q[idx];
		rd.press_stamp  = press_stamp_q[idx];
		rd.repeat_stamp = repeat_stamp_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= '0;
			pressed_q      <= '0;
			touched_q      <= '0;
			selected_q     <= '0;
			armed_q        <= '0;
			press_stamp_q  <= '0;
			repeat_stamp_q <= '0;
		end else if (en) begin
			if (wr.clr) begin
				// pressed, touched and selected survive a clear
				mode_q         <= '0;
				armed_q        <= '0;
				press_stamp_q  <= '0;
				repeat_stamp_q <= '0;
			end else if (wr.we) begin
				mode_q[idx]         <= wr.ent.mode;
				pressed_q[idx]      <= wr.ent.pressed;
				touched_q[idx]      <= wr.ent.touched;
				selected_q[idx]     <= wr.ent.selected;
				armed_q[idx]        <= wr.ent.armed;
				press_stamp_q[idx]  <= wr.ent.press_stamp;
				repeat_stamp_q[idx] <= wr.ent.repeat_stamp;
			end
		end
	end

endmodule

[rtl/core/bev_calc.sv]
// Event decision for one item: new entry state and the result item.
module bev_calc (
	input  bev_pkg::item_t   item,
	input  bev_pkg::cfg_t    cfg,
	input  bev_pkg::entry_t  rd,
	output bev_pkg::result_t res,
	output bev_pkg::wr_t     wr
);

	logic        valid_btn;
	logic [7:0]  m;
	logic [31:0] held;
	logic [31:0] excess;
	logic [31:0] since_rep;
	logic [9:0]  ex_clamp;
	logic [7:0]  speedup;
	logic [17:0] prod;
	logic [8:0]  steps;
	logic [17:0] thr;
	logic        rep_active;
	logic        rep_fire;
	logic        long_hit;

	function automatic bev_pkg::led_t idle_led(input logic [7:0] md);
		if (md[bev_pkg::M_USERDRAW])
			return bev_pkg::LED_NONE;
		return md[bev_pkg::M_TOUCH] ? bev_pkg::LED_TOUCH : bev_pkg::LED_DEFAULT;
	endfunction

	assign valid_btn = int'(item.button) < bev_pkg::NBTN;
	assign m         = rd.mode;

	assign held       = item.now_ms - rd.press_stamp;
	assign rep_active = m[bev_pkg::M_REPEAT] && (held > {16'd0, cfg.repeat_delay_ms});
	assign long_hit   = m[bev_pkg::M_LONG] && (held > {16'd0, cfg.long_press_ms});
	assign excess     = held - {16'd0, cfg.repeat_delay_ms};
	assign ex_clamp   = (excess > 32'(bev_pkg::REPEAT_SPAN)) ? 10'(bev_pkg::REPEAT_SPAN)
		: excess[9:0];
	assign speedup    = (cfg.repeat_speedup_ms > cfg.repeat_slow_ms) ? cfg.repeat_slow_ms
		: cfg.repeat_speedup_ms;
	assign prod       = 18'(speedup) * 18'(ex_clamp);
	assign since_rep  = item.now_ms - rd.repeat_stamp;

	// since > slow - floor(prod/SPAN)  <=>  since > slow, or prod >= SPAN*(slow-since+1)
	assign steps    = {1'b0, cfg.repeat_slow_ms} - {1'b0, since_rep[7:0]} + 9'd1;
	assign thr      = 18'(steps) * 18'(bev_pkg::REPEAT_SPAN);
	assign rep_fire = (since_rep > {24'd0, cfg.repeat_slow_ms}) || (prod >= thr);

	always_comb begin
		res    = '0;
		wr.we  = 1'b0;
		wr.clr = 1'b0;
		wr.ent = rd;
		unique case (bev_pkg::cmd_t'(item.cmd))
			bev_pkg::CMD_CLEAR: begin
				wr.clr         = 1'b1;
				res.led_action = bev_pkg::LED_ALL_OFF;
			end
			bev_pkg::CMD_MODE: begin
				if (valid_btn) begin
					wr.we          = 1'b1;
					wr.ent.mode    = item.mode;
					res.led_action = item.mode[bev_pkg::M_USERDRAW] ? bev_pkg::LED_NONE
						: bev_pkg::LED_DEFAULT;
				end
			end
			bev_pkg::CMD_SAMPLE: begin
				if (valid_btn && m != 8'd0) begin
					if (item.down != rd.pressed) begin
						wr.we = 1'b1;
						if (item.down) begin
							wr.ent.pressed     = 1'b1;
							wr.ent.touched     = 1'b1;
							wr.ent.armed       = 1'b1;
							wr.ent.press_stamp = item.now_ms;
							res.ev_press       = m[bev_pkg::M_PRESS];
							if (!m[bev_pkg::M_REPEAT])
								res.led_action = bev_pkg::LED_PRESSED;
						end else begin
							wr.ent.pressed = 1'b0;
							if (rd.armed) begin
								if (!m[bev_pkg::M_USERDRAW]) begin
									res.led_action = idle_led(m);
									if (m[bev_pkg::M_TOGGLE]) begin
										wr.ent.selected = !rd.selected;
										if (!rd.selected)
											res.led_action = bev_pkg::LED_SELECTED;
									end
								end
								wr.ent.armed   = 1'b0;
								res.ev_release = m[bev_pkg::M_RELEASE];
								res.ev_click   = m[bev_pkg::M_CLICK];
							end
						end
					end else if (item.down && rd.armed) begin
						// repeat window shadows the long-press check
						if (rep_active) begin
							if (rep_fire) begin
								wr.we               = 1'b1;
								wr.ent.repeat_stamp = item.now_ms;
								res.ev_press        = 1'b1;
							end
						end else if (long_hit) begin
							wr.we             = 1'b1;
							wr.ent.armed      = 1'b0;
							res.ev_long_click = 1'b1;
							res.led_action    = idle_led(m);
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (valid_btn && (item.cmd == bev_pkg::CMD_SAMPLE || item.cmd == bev_pkg::CMD_MODE
			|| item.cmd == bev_pkg::CMD_CLEAR)) begin
			res.pressed     = wr.ent.pressed;
			res.is_selected = wr.ent.selected;
			res.was_touched = wr.ent.touched;
		end
	end

endmodule

[rtl/core/button_event_generator.sv]
// Button event generator. Takes one item per clock while not stalled and gives one result item per item:
// the item is held in the input register and its result is loaded into the result register
// once that register is free or its result is taken. The per-button state lives in flops
// and is read and updated between the two registers and written back as the result is loaded, so
// consecutive items for the same button need no forwarding. A result waiting at the output
// does not stop the next item from entering the input register; the input stalls only when
// both registers are full and the result is not taken. Configuration writes are taken in
// any cycle and apply to items that leave the input register afterwards.
module button_event_generator (
	input  logic        clk,
	input  logic        arst_n,
	bev_in_if.sink      req,
	bev_out_if.source   rsp,
	bev_cfg_if.sink     cfg
);

	logic                valid_s1;
	bev_pkg::item_t      item_s1;
	logic                out_valid_q;
	bev_pkg::result_t    res_q;
	bev_pkg::cfg_t       cfg_q;
	logic                adv;
	bev_pkg::entry_t     rd;
	bev_pkg::wr_t        wr;
	bev_pkg::result_t    res;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms     <= bev_pkg::LONG_PRESS_RST;
			cfg_q.repeat_delay_ms   <= bev_pkg::REP_DELAY_RST;
			cfg_q.repeat_slow_ms    <= bev_pkg::REP_SLOW_RST;
			cfg_q.repeat_speedup_ms <= bev_pkg::REP_SPEED_RST;
		end else if (cfg.valid) begin
			unique case (bev_pkg::cfg_idx_t'(cfg.index))
				bev_pkg::CFG_LONG_PRESS: cfg_q.long_press_ms     <= cfg.data;
				bev_pkg::CFG_REP_DELAY:  cfg_q.repeat_delay_ms   <= cfg.data;
				bev_pkg::CFG_REP_SLOW:   cfg_q.repeat_slow_ms    <= cfg.data[7:0];
				bev_pkg::CFG_REP_SPEED:  cfg_q.repeat_speedup_ms <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (adv)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd    <= req.cmd;
			item_s1.button <= req.button;
			item_s1.down   <= req.down;
			item_s1.now_ms <= req.now_ms;
			item_s1.mode   <= req.mode;
		end
		if (adv)
			res_q <= res;
	end

	bev_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (bev_pkg::BTN_W'(item_s1.button)),
		.en     (adv),
		.wr     (wr),
		.rd     (rd)
	);

	bev_calc u_calc (
		.item (item_s1),
		.cfg  (cfg_q),
		.rd   (rd),
		.res  (res),
		.wr   (wr)
	);

	assign rsp.valid         = out_valid_q;
	assign rsp.ev_press      = res_q.ev_press;
	assign rsp.ev_release    = res_q.ev_release;
	assign rsp.ev_click      = res_q.ev_click;
	assign rsp.ev_long_click = res_q.ev_long_click;
	assign rsp.led_action    = res_q.led_action;
	assign rsp.pressed       = res_q.pressed;
	assign rsp.is_selected   = res_q.is_selected;
	assign rsp.was_touched   = res_q.was_touched;

	// an accepted item always lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted item lost before the input register");

	// a held item stays until the result register frees up
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stalled item dropped");

	// long click ends the press cycle: no other event in the same result
	a_long_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ev_long_click |-> !rsp.ev_press && !rsp.ev_release && !rsp.ev_click)
		else $error("long click mixed with other events");

	// a clear never reports an event
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.led_action == bev_pkg::LED_ALL_OFF |->
		!rsp.ev_press && !rsp.ev_release && !rsp.ev_click && !rsp.ev_long_click)
		else $error("event flagged on a clear");

endmodule

[tb/sv/button_event_generator_tb.sv]
// Self-checking testbench of the button event generator: directed and random items.
module button_event_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bev_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [7:0] MK_PRESS    = 8'b1 << M_PRESS;
	localparam logic [7:0] MK_RELEASE  = 8'b1 << M_RELEASE;
	localparam logic [7:0] MK_CLICK    = 8'b1 << M_CLICK;
	localparam logic [7:0] MK_LONG     = 8'b1 << M_LONG;
	localparam logic [7:0] MK_REPEAT   = 8'b1 << M_REPEAT;
	localparam logic [7:0] MK_TOGGLE   = 8'b1 << M_TOGGLE;
	localparam logic [7:0] MK_TOUCH    = 8'b1 << M_TOUCH;
	localparam logic [7:0] MK_USERDRAW = 8'b1 << M_USERDRAW;

	// Tracks every button as the block should, and queues the result of each item.
	class button_scoreboard;
		logic [7:0]  mask [NBTN];
		bit          pressed [NBTN];
		bit          touched [NBTN];
		bit          selected [NBTN];
		bit          armed [NBTN];
		logic [31:0] t_press [NBTN];
		logic [31:0] t_repeat [NBTN];
		logic [15:0] long_ms;
		logic [15:0] delay_ms;
		logic [7:0]  slow_ms;
		logic [7:0]  speed_ms;
		result_t     due [$];
		int          errors;

		function new();
			long_ms  = LONG_PRESS_RST;
			delay_ms = REP_DELAY_RST;
			slow_ms  = REP_SLOW_RST;
			speed_ms = REP_SPEED_RST;
			errors   = 0;
			for (int i = 0; i < NBTN; i++) begin
				mask[i]     = '0;
				pressed[i]  = 0;
				touched[i]  = 0;
				selected[i] = 0;
				armed[i]    = 0;
				t_press[i]  = '0;
				t_repeat[i] = '0;
			end
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] v);
			case (idx)
				CFG_LONG_PRESS: long_ms  = v;
				CFG_REP_DELAY:  delay_ms = v;
				CFG_REP_SLOW:   slow_ms  = v[7:0];
				CFG_REP_SPEED:  speed_ms = v[7:0];
			endcase
		endfunction

		function led_t rest_led(logic [7:0] m);
			if (m[M_USERDRAW])
				return LED_NONE;
			return m[M_TOUCH] ? LED_TOUCH : LED_DEFAULT;
		endfunction

		function void note_item(logic [1:0] cmd, logic [4:0] button, logic down,
				logic [31:0] now, logic [7:0] mode);
			result_t     r;
			logic [7:0]  m;
			logic [31:0] held, ex, sp, interval, since;
			bit          in_range;
			r = '0;
			in_range = button < NBTN;
			if (cmd == CMD_CLEAR) begin
				for (int i = 0; i < NBTN; i++) begin
					mask[i]     = '0;
					armed[i]    = 0;
					t_press[i]  = '0;
					t_repeat[i] = '0;
				end
				r.led_action = LED_ALL_OFF;
			end else if (cmd == CMD_MODE && in_range) begin
				mask[button] = mode;
				r.led_action = mode[M_USERDRAW] ? LED_NONE : LED_DEFAULT;
			end else if (cmd == CMD_SAMPLE && in_range && mask[button] != 0) begin
				m = mask[button];
				if (down != pressed[button]) begin
					if (down) begin
						pressed[button] = 1;
						touched[button] = 1;
						armed[button]   = 1;
						t_press[button] = now;
						if (!m[M_REPEAT])
							r.led_action = LED_PRESSED;
						r.ev_press = m[M_PRESS];
					end else begin
						pressed[button] = 0;
						if (armed[button]) begin
							if (!m[M_USERDRAW]) begin
								r.led_action = rest_led(m);
								if (m[M_TOGGLE]) begin
									selected[button] = !selected[button];
									if (selected[button])
										r.led_action = LED_SELECTED;
								end
							end
							armed[button] = 0;
							r.ev_release  = m[M_RELEASE];
							r.ev_click    = m[M_CLICK];
						end
					end
				end else if (down && armed[button]) begin
					held = now - t_press[button];
					if (m[M_REPEAT] && held > delay_ms) begin
						ex = held - delay_ms;
						if (ex > REPEAT_SPAN)
							ex = REPEAT_SPAN;
						sp = (speed_ms > slow_ms) ? slow_ms : speed_ms;
						interval = slow_ms - (sp * ex) / REPEAT_SPAN;
						since = now - t_repeat[button];
						if (since > interval) begin
							r.ev_press = 1;
							t_repeat[button] = now;
						end
					end else if (m[M_LONG] && held > long_ms) begin
						r.led_action    = rest_led(m);
						armed[button]   = 0;
						r.ev_long_click = 1;
					end
				end
			end
			// unused command leaves every field at zero; out-of-range index leaves the status fields at zero
			if ((cmd == CMD_CLEAR || cmd == CMD_MODE || cmd == CMD_SAMPLE) && in_range) begin
				r.pressed     = pressed[button];
				r.is_selected = selected[button];
				r.was_touched = touched[button];
			end
			due.push_back(r);
		endfunction

		function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check(result_t got);
			result_t want;
			if (due.size() == 0) begin
				$error("result item with none expected");
				errors++;
				return;
			end
			want = due.pop_front();
			cmp_field("ev_press", want.ev_press, got.ev_press);
			cmp_field("ev_release", want.ev_release, got.ev_release);
			cmp_field("ev_click", want.ev_click, got.ev_click);
			cmp_field("ev_long_click", want.ev_long_click, got.ev_long_click);
			cmp_field("led_action", want.led_action, got.led_action);
			cmp_field("pressed", want.pressed, got.pressed);
			cmp_field("is_selected", want.is_selected, got.is_selected);
			cmp_field("was_touched", want.was_touched, got.was_touched);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bev_in_if  req();
	bev_out_if rsp();
	bev_cfg_if cfg();

	button_event_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	button_scoreboard sb = new;

	int          send_idle_pct = 0;
	int          rcv_idle_pct  = 0;
	int          items_sent    = 0;
	int          hold_req      = 0;
	int          hold_seen     = 0;
	int          hold_left     = 0;
	logic [31:0] clock_ms;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: check accepted items, then pick ready for the next edge
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check(result_t'({rsp.ev_press, rsp.ev_release, rsp.ev_click,
				rsp.ev_long_click, rsp.led_action, rsp.pressed, rsp.is_selected,
				rsp.was_touched}));
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [4:0] button,
			input logic down, input logic [31:0] now, input logic [7:0] mode);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid  <= 1'b1;
		req.cmd    <= cmd;
		req.button <= button;
		req.down   <= down;
		req.now_ms <= now;
		req.mode   <= mode;
		do @(posedge clk); while (!req.ready);
		sb.note_item(cmd, button, down, now, mode);
		if (!(cmd == CMD_UNUSED || (cmd != CMD_CLEAR && button >= NBTN)))
			items_sent++;
	endtask

	task automatic wait_results_done();
		while (sb.due.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] lp, input logic [15:0] rd,
			input logic [15:0] rs, input logic [15:0] su);
		logic [15:0] vals [4];
		cfg_idx_t    regs [4];
		vals = '{lp, rd, rs, su};
		regs = '{CFG_LONG_PRESS, CFG_REP_DELAY, CFG_REP_SLOW, CFG_REP_SPEED};
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= regs[i];
			cfg.data  <= vals[i];
			do @(posedge clk); while (!cfg.ready);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg.valid <= 1'b0;
	endtask

	task automatic send_noise();
		send_item(2'($urandom_range(3)), 5'($urandom_range(31)), 1'($urandom_range(1)),
			$urandom(), 8'($urandom_range(255)));
	endtask

	// one press/hold/release of a button, with other buttons and noise mixed in
	task automatic run_episode();
		logic [4:0] b;
		int         holds;
		b = 5'($urandom_range(NBTN - 1));
		if ($urandom_range(1))
			send_item(CMD_MODE, b, 1'($urandom_range(1)), $urandom(),
				8'($urandom_range(1, 255)));
		clock_ms += $urandom_range(0, 300);
		send_item(CMD_SAMPLE, b, 1'b1, clock_ms, 8'($urandom_range(255)));
		holds = $urandom_range(0, 8);
		repeat (holds) begin
			clock_ms += ($urandom_range(3) == 0) ? $urandom_range(0, 5) : $urandom_range(20, 400);
			case ($urandom_range(9))
				0: send_item(CMD_SAMPLE, 5'($urandom_range(NBTN - 1)), 1'($urandom_range(1)),
					clock_ms, 8'($urandom_range(255)));
				1: send_noise();
				default: send_item(CMD_SAMPLE, b, 1'b1, clock_ms, 8'($urandom_range(255)));
			endcase
		end
		if ($urandom_range(6) != 0) begin
			clock_ms += $urandom_range(0, 300);
			send_item(CMD_SAMPLE, b, 1'b0, clock_ms, 8'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(input int quota);
		int stop_at;
		stop_at  = items_sent + quota;
		clock_ms = $urandom();
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 8)
				send_noise();
			else
				run_episode();
		end
	endtask

	task automatic run_directed();
		// zero mask, unused command, out-of-range index
		send_item(CMD_SAMPLE, 5'd0, 1'b1, 32'd0, 8'hFF);
		send_item(CMD_UNUSED, 5'd3, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		send_item(CMD_MODE, 5'd25, 1'b0, 32'd0, 8'hFF);
		send_item(CMD_SAMPLE, 5'd31, 1'b1, 32'd10, 8'h00);
		send_item(CMD_MODE, 5'd5, 1'b0, 32'd0, 8'h00);
		// toggle: select, then deselect
		send_item(CMD_MODE, 5'd0, 1'b0, 32'd0,
			MK_PRESS | MK_RELEASE | MK_CLICK | MK_TOGGLE | MK_TOUCH);
		send_item(CMD_SAMPLE, 5'd0, 1'b1, 32'd1000, 8'h00);
		send_item(CMD_SAMPLE, 5'd0, 1'b0, 32'd1150, 8'h00);
		send_item(CMD_SAMPLE, 5'd0, 1'b1, 32'd1200, 8'h00);
		send_item(CMD_SAMPLE, 5'd0, 1'b0, 32'd1250, 8'h00);
		// long click with user draw, then held and released unarmed
		send_item(CMD_MODE, 5'd1, 1'b1, 32'd0, MK_LONG | MK_USERDRAW | MK_PRESS);
		send_item(CMD_SAMPLE, 5'd1, 1'b1, 32'd1300, 8'h00);
		send_item(CMD_SAMPLE, 5'd1, 1'b1, 32'd2200, 8'h00);
		send_item(CMD_SAMPLE, 5'd1, 1'b1, 32'd2300, 8'h00);
		send_item(CMD_SAMPLE, 5'd1, 1'b0, 32'd2400, 8'h00);
		// auto-repeat, slow then at full speed
		send_item(CMD_MODE, 5'd2, 1'b0, 32'd0, MK_REPEAT | MK_PRESS | MK_LONG);
		send_item(CMD_SAMPLE, 5'd2, 1'b1, 32'd5000, 8'h00);
		send_item(CMD_SAMPLE, 5'd2, 1'b1, 32'd5301, 8'h00);
		send_item(CMD_SAMPLE, 5'd2, 1'b1, 32'd5350, 8'h00);
		send_item(CMD_SAMPLE, 5'd2, 1'b1, 32'd6500, 8'h00);
		send_item(CMD_SAMPLE, 5'd2, 1'b0, 32'd6600, 8'h00);
		// hold across the time wrap
		send_item(CMD_MODE, 5'd24, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		send_item(CMD_SAMPLE, 5'd24, 1'b1, 32'hFFFF_FFFF, 8'h00);
		send_item(CMD_SAMPLE, 5'd24, 1'b1, 32'h0000_0200, 8'h00);
		// clear, with the status of a button and of no button
		send_item(CMD_CLEAR, 5'd0, 1'b0, 32'd0, 8'h00);
		send_item(CMD_CLEAR, 5'd30, 1'b1, 32'd0, 8'hFF);
	endtask

	initial begin
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.cmd    = CMD_SAMPLE;
		req.button = '0;
		req.down   = 1'b0;
		req.now_ms = '0;
		req.mode   = '0;
		rsp.ready  = 1'b0;
		cfg.valid  = 1'b0;
		cfg.index  = CFG_LONG_PRESS;
		cfg.data   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < 6; ph++) begin
			req.valid <= 1'b0;
			wait_results_done();
			case (ph)
				0: begin
					send_idle_pct = 0;
					rcv_idle_pct  = 0;
				end
				1: begin
					send_idle_pct = 71;
					rcv_idle_pct  = 0;
					load_config(16'd0, 16'd0, 16'd0, 16'd0);
				end
				2: begin
					send_idle_pct = 0;
					rcv_idle_pct  = 71;
					load_config(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h00FF);
				end
				3: begin
					send_idle_pct = 20;
					rcv_idle_pct  = 20;
					// speedup above the slow interval saturates
					load_config(16'd500, 16'd200, 16'd40, 16'd200);
				end
				4: begin
					send_idle_pct = 0;
					rcv_idle_pct  = 0;
					load_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1500)),
						16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
					hold_req++;
				end
				default: begin
					send_idle_pct = 20;
					rcv_idle_pct  = 20;
					load_config(LONG_PRESS_RST, REP_DELAY_RST, 16'(REP_SLOW_RST),
						16'(REP_SPEED_RST));
				end
			endcase
			run_phase(115);
		end
		req.valid <= 1'b0;
		wait_results_done();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/core/bev_pkg.sv
rtl/core/bev_in_if.sv
rtl/core/bev_out_if.sv
rtl/core/bev_cfg_if.sv
rtl/core/bev_table.sv
rtl/core/bev_calc.sv
rtl/core/button_event_generator.sv
tb/sv/button_event_generator_tb.sv
